// File: rtl/core/stghp_pkg.sv
// Shared types, constants and helpers for the scan telegram hex parser.
package stghp_pkg;

	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_SPACE = 8'h20;
	localparam logic [3:0]  MARK_LEN   = 4'd8;
	localparam logic [31:0] TOKEN_MAX  = 32'h7FFF_FFFF;
	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_SEP    = 3'd1,
		PH_ANGLE  = 3'd2,
		PH_STEP   = 3'd3,
		PH_COUNT  = 3'd4,
		PH_DATA   = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [31:0] acc;
		logic        valid;
		logic        nonempty;
	} token_t;

	typedef struct packed {
		logic [31:0] value;
		logic [15:0] index;
		logic        ok;
		logic        last;
	} point_t;

	localparam token_t TOKEN_CLEAR = '{acc: 32'd0, valid: 1'b1, nonempty: 1'b0};

	typedef struct packed {
		logic       is_hex;
		logic [3:0] nib;
	} nibble_t;

	function automatic nibble_t hex_nibble(input logic [7:0] c);
		nibble_t r;
		r.is_hex = 1'b1;
		r.nib    = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nib = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.nib = 4'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.nib = 4'(c - 8'h61 + 8'd10);
		end else begin
			r.is_hex = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/stghp_token.sv
// Hex token accumulator: folds one character into the token being read.
module stghp_token import stghp_pkg::*; (
	input  token_t     tok_cur,
	input  logic [7:0] char_in,
	output token_t     tok_next
);

	nibble_t hn;

	always_comb begin
		hn       = hex_nibble(char_in);
		tok_next = tok_cur;
		tok_next.nonempty = 1'b1;
		if (!hn.is_hex) begin
			tok_next.valid = 1'b0;
		end else if (tok_cur.valid) begin
			// stop accumulating once the value would pass the signed 32-bit limit
			if (tok_cur.acc > (TOKEN_MAX >> 4)) begin
				tok_next.valid = 1'b0;
			end else begin
				tok_next.acc = {tok_cur.acc[27:0], hn.nib};
			end
		end
	end

endmodule

// File: rtl/core/stghp_parser.sv
// Telegram parse state machine: marker search, header skip, count and data tokens.
module stghp_parser import stghp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] char_in,
	input  logic       first_in,
	input  logic       double_values,
	output logic       emit,
	output point_t     point
);

	phase_t      phase_q, phase_d, phase_c;
	logic [3:0]  zero_run_q, zero_run_d, zero_run_c;
	token_t      tok_q, tok_d, tok_c, tok_fold;
	logic [15:0] remaining_q, remaining_d, remaining_c;
	logic [15:0] emitted_q, emitted_d, emitted_c;
	logic        is_space;
	logic        tok_ok;
	logic [3:0]  zero_inc;
	logic [31:0] count_val;
	logic [15:0] remaining_dec;

	stghp_token u_token (
		.tok_cur (tok_c),
		.char_in (char_in),
		.tok_next(tok_fold)
	);

	always_comb begin
		// a first byte restarts the parse before this byte is looked at
		if (first_in) begin
			phase_c     = PH_SEARCH;
			zero_run_c  = 4'd0;
			tok_c       = TOKEN_CLEAR;
			remaining_c = 16'd0;
			emitted_c   = 16'd0;
		end else begin
			phase_c     = phase_q;
			zero_run_c  = zero_run_q;
			tok_c       = tok_q;
			remaining_c = remaining_q;
			emitted_c   = emitted_q;
		end

		is_space      = (char_in == CHAR_SPACE);
		tok_ok        = tok_c.valid && tok_c.nonempty;
		zero_inc      = zero_run_c + 4'd1;
		count_val     = tok_ok ? tok_c.acc : 32'd0;
		remaining_dec = remaining_c - 16'd1;

		phase_d     = phase_c;
		zero_run_d  = zero_run_c;
		tok_d       = tok_c;
		remaining_d = remaining_c;
		emitted_d   = emitted_c;
		emit        = 1'b0;
		point.value = 32'd0;
		point.index = emitted_c;
		point.ok    = tok_ok;
		point.last  = (remaining_c == 16'd1);

		unique case (phase_c)
			PH_SEARCH: begin
				if (char_in == CHAR_ZERO) begin
					if (zero_inc >= MARK_LEN) begin
						zero_run_d = 4'd0;
						phase_d    = PH_SEP;
					end else begin
						zero_run_d = zero_inc;
					end
				end else begin
					zero_run_d = 4'd0;
				end
			end
			PH_SEP: phase_d = PH_ANGLE;
			PH_ANGLE: begin
				if (is_space) phase_d = PH_STEP;
			end
			PH_STEP: begin
				if (is_space) begin
					phase_d = PH_COUNT;
					tok_d   = TOKEN_CLEAR;
				end
			end
			PH_COUNT: begin
				if (!is_space) begin
					tok_d = tok_fold;
				end else begin
					remaining_d = (count_val > 32'(COUNT_MAX)) ? COUNT_MAX : count_val[15:0];
					emitted_d   = 16'd0;
					tok_d       = TOKEN_CLEAR;
					phase_d     = (count_val == 32'd0) ? PH_DONE : PH_DATA;
				end
			end
			PH_DATA: begin
				if (!is_space) begin
					tok_d = tok_fold;
				end else begin
					emit = 1'b1;
					if (tok_ok) begin
						point.value = double_values ? {tok_c.acc[30:0], 1'b0} : tok_c.acc;
					end
					emitted_d   = emitted_c + 16'd1;
					remaining_d = remaining_dec;
					if (remaining_dec == 16'd0) phase_d = PH_DONE;
					tok_d = TOKEN_CLEAR;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEARCH;
			zero_run_q  <= 4'd0;
			tok_q       <= TOKEN_CLEAR;
			remaining_q <= 16'd0;
			emitted_q   <= 16'd0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			zero_run_q  <= zero_run_d;
			tok_q       <= tok_d;
			remaining_q <= remaining_d;
			emitted_q   <= emitted_d;
		end
	end

endmodule

// File: rtl/core/scan_telegram_hex_parser_top.sv
// Top level of the scan telegram hex parser: input register, parser and result register.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_ready | data_byte, first_byte
//  out     | out_valid/out_ready | point_value, point_index, point_ok, last_point
//  cfg     | cfg_we              | cfg_wdata (double_values)
//
// One byte per cycle unless the output stalls; a byte waits in the input register and its
// point, if any, is loaded into the result register as the byte leaves the input register.
// The parse state steps once per byte when the result register is free or being drained.
// A stalled output holds the result register and the input register; in_ready drops
// only while both are full and out_ready is low.
// Reset clears the parse state to marker search and sets double_values to one.
module scan_telegram_hex_parser_top import stghp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] point_value,
	output logic [15:0] point_index,
	output logic        point_ok,
	output logic        last_point,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       first_byte_s1;
	logic       double_values_q;
	logic       out_valid_q;
	point_t     point_q;
	logic       advance;
	logic       emit;
	point_t     point;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_values_q <= 1'b1;
		end else if (cfg_we) begin
			double_values_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1  <= data_byte;
			first_byte_s1 <= first_byte;
		end
	end

	stghp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.char_in      (data_byte_s1),
		.first_in     (first_byte_s1),
		.double_values(double_values_q),
		.emit         (emit),
		.point        (point)
	);

	// load a new point on emit, otherwise drop the old one once it transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			point_q <= point;
		end
	end

	assign out_valid   = out_valid_q;
	assign point_value = point_q.value;
	assign point_index = point_q.index;
	assign point_ok    = point_q.ok;
	assign last_point  = point_q.last;

endmodule
